// File: rtl/kvt_pkg.sv
// kvt_pkg: shared types and constants for the key-value table core.
// Request and response payload structs, operation codes, field widths.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int REV_W   = 32;
	localparam int CAP_W   = 5;
	localparam int OCC_W   = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [REV_W-1:0] REV_RESET = 32'd1;

	typedef enum logic [1:0] {
		FUNC_STORE  = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data_in;
		logic             format_ok;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] data_out;
		logic [REV_W-1:0] stored_revision;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

endpackage

// File: rtl/kvt_ram.sv
// kvt_ram: single-port-write, single-port-read memory with registered read data.
// Holds key or value words of the table; contents undefined until written.
// No dependencies.
`timescale 1ns / 1ps

module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/fifo_evict_key_value_table_core.sv
// fifo_evict_key_value_table_core: fully associative key-value table, FIFO eviction.
// Sequencer with one shared key comparator over a key RAM and a value RAM.
// Depends on kvt_pkg and kvt_ram.
//
//   port group            dir   handshake              payload
//   in_valid/in_stall     in    valid/stall            in_req  (kvt_pkg::req_t)
//   out_valid/out_stall   out   valid/stall            out_rsp (kvt_pkg::rsp_t)
//   cfg_we/cfg_wdata      in    write enable           capacity (5 bits)
//
// Store and lookup read the key RAM one entry per cycle, and the single comparator checks
// each entry the cycle after it is read; a hit ends the scan early.
// Clear, no-op and refused stores skip the scan and go straight to the result state.
// Reset clears occupancy, oldest position, and sets the revision counter to one.
// A waiting result holds in the output register; the next request is accepted the cycle
// after that load, and its result waits until that register frees up.
`timescale 1ns / 1ps

module fifo_evict_key_value_table_core #(
	parameter int DEPTH = kvt_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  kvt_pkg::req_t             in_req,
	output logic                      out_valid,
	input  logic                      out_stall,
	output kvt_pkg::rsp_t             out_rsp,
	input  logic                      cfg_we,
	input  logic [kvt_pkg::CAP_W-1:0] cfg_wdata
);

	import kvt_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;
	localparam int SW   = CNTW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_VRD,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     oldest_q;
	logic [CNTW-1:0]   count_q;
	logic [REV_W-1:0]  rev_ctr_q;

	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  data_q;

	logic [AW-1:0]     scan_slot_q;
	logic [CNTW-1:0]   idx_q;
	logic              vld_s1;
	logic [AW-1:0]     slot_s1;
	logic              hit_q;
	logic [AW-1:0]     slot_q;

	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [KEY_W-1:0]  key_rd;
	logic [VAL_W-1:0]  val_rd;

	logic              in_acc;
	logic              issuing;
	logic              hit;
	logic [CMPW-1:0]   cap_eff;
	logic              evict;
	logic              refused;
	logic [SW-1:0]     tail_sum;
	logic [AW-1:0]     tail;
	logic              key_we;
	logic              val_we;
	logic [AW-1:0]     val_waddr;
	logic              out_load;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	assign cap_eff  = (CMPW'(cap_q) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_q);
	assign refused  = (cap_eff == '0) || !in_req.format_ok || (rev_ctr_q == '0);
	assign issuing  = (idx_q < count_q);
	assign hit      = vld_s1 && (key_rd == key_q);
	assign evict    = (CMPW'(count_q) >= cap_eff) && (count_q != '0);
	assign tail_sum = SW'(oldest_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

	assign key_we    = (state_q == ST_ACT) && (func_q == FUNC_STORE) && !hit_q;
	assign val_we    = (state_q == ST_ACT) && (func_q == FUNC_STORE);
	assign val_waddr = hit_q ? slot_q : tail;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	kvt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (tail),
		.wdata (key_q),
		.raddr (scan_slot_q),
		.rdata (key_rd)
	);

	kvt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (data_q),
		.raddr (slot_q),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			oldest_q    <= '0;
			count_q     <= '0;
			rev_ctr_q   <= REV_RESET;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						func_q                <= in_req.func;
						key_q                 <= in_req.key;
						data_q                <= in_req.data_in;
						res_q.ok              <= (in_req.func == FUNC_CLEAR);
						res_q.data_out        <= '0;
						res_q.stored_revision <= '0;
						res_q.occupancy       <= '0;
						scan_slot_q           <= oldest_q;
						idx_q                 <= '0;
						vld_s1                <= 1'b0;
						hit_q                 <= 1'b0;
						case (in_req.func)
							FUNC_STORE: begin
								state_q <= refused ? ST_DONE : ST_SCAN;
							end
							FUNC_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							FUNC_CLEAR: begin
								count_q   <= '0;
								oldest_q  <= '0;
								state_q   <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					slot_s1 <= scan_slot_q;
					if (hit) begin
						hit_q   <= 1'b1;
						slot_q  <= slot_s1;
						vld_s1  <= 1'b0;
						state_q <= ST_ACT;
					end else if (issuing) begin
						vld_s1      <= 1'b1;
						idx_q       <= idx_q + 1'b1;
						scan_slot_q <= slot_inc(scan_slot_q);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_ACT;
						end
					end
				end
				ST_ACT: begin
					if (func_q == FUNC_STORE) begin
						res_q.ok              <= 1'b1;
						res_q.stored_revision <= rev_ctr_q;
						rev_ctr_q             <= rev_ctr_q + 1'b1;
						if (!hit_q) begin
							if (evict) begin
								oldest_q <= slot_inc(oldest_q);
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= hit_q ? ST_VRD : ST_DONE;
					end
				end
				ST_VRD: begin
					res_q.ok       <= 1'b1;
					res_q.data_out <= val_rd;
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_q.ok              <= res_q.ok;
						out_q.data_out        <= res_q.data_out;
						out_q.stored_revision <= res_q.stored_revision;
						out_q.occupancy       <= OCC_W'(count_q);
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("occupancy exceeds table depth");

	a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage valid outside key scan");

	a_rev_only_in_act: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACT) |=> $stable(rev_ctr_q))
		else $error("revision counter moved outside store update");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACT && hit_q) |=> $stable(count_q) && $stable(oldest_q))
		else $error("in-place overwrite changed replacement order");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without finishing a request");
`endif

endmodule
